// ----- rtl/rllc_pkg.sv -----
`timescale 1ns / 1ps

package rllc_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int VALUE_BITS = 16;

  localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_IDX_BITS = 4;
  localparam int ENTRY_COUNT_BITS = 5;
  localparam int REG_BITS = 16;
  localparam int LEVEL_BITS = 2;

  localparam int DVD_BITS = VALUE_BITS + 10;
  localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);
  localparam logic [DVD_BITS-1:0] PERMILLE_SCALE = DVD_BITS'(1000);

  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_MIN_CAPACITY = 3'd1,
    REG_WARN_PERMILLE = 3'd2,
    REG_FULL_PERMILLE = 3'd3,
    REG_OVER_PERMILLE = 3'd4
  } reg_idx_t;

  typedef enum logic [LEVEL_BITS-1:0] {
    LEVEL_NORMAL = 2'd0,
    LEVEL_WARNING = 2'd1,
    LEVEL_FULL = 2'd2,
    LEVEL_OVERLOAD = 2'd3
  } level_t;

  typedef struct packed {
    logic [ENTRY_COUNT_BITS-1:0] entry_count;
    logic [REG_BITS-1:0] min_capacity;
    logic [REG_BITS-1:0] warn_permille;
    logic [REG_BITS-1:0] full_permille;
    logic [REG_BITS-1:0] over_permille;
  } cfg_regs_t;

endpackage

// ----- rtl/rllc_if.sv -----
`timescale 1ns / 1ps

interface rllc_in_if;
  import rllc_pkg::*;

  logic valid;
  logic ready;
  logic func;
  logic [ENTRY_IDX_BITS-1:0] entry_index;
  logic [VALUE_BITS-1:0] entry_radius;
  logic [VALUE_BITS-1:0] entry_capacity;
  logic [VALUE_BITS-1:0] trolley_position;
  logic [VALUE_BITS-1:0] load_weight;

  modport source (
    output valid, func, entry_index, entry_radius, entry_capacity,
           trolley_position, load_weight,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_radius, entry_capacity,
           trolley_position, load_weight,
    output ready
  );
endinterface

interface rllc_out_if;
  import rllc_pkg::*;

  logic valid;
  logic ready;
  logic [LEVEL_BITS-1:0] level;
  logic [VALUE_BITS-1:0] load_permille;
  logic capacity_fault;

  modport source (
    output valid, level, load_permille, capacity_fault,
    input  ready
  );

  modport sink (
    input  valid, level, load_permille, capacity_fault,
    output ready
  );
endinterface

// ----- rtl/rllc_ram.sv -----
`timescale 1ns / 1ps

module rllc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rllc_cfg.sv -----
`timescale 1ns / 1ps

module rllc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rllc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [rllc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [rllc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output rllc_pkg::cfg_regs_t                regs
);
  import rllc_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  reg_idx_t reg_idx;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ENTRY_COUNT:   regs_nxt.entry_count = pwdata[ENTRY_COUNT_BITS-1:0];
        REG_MIN_CAPACITY:  regs_nxt.min_capacity = pwdata[REG_BITS-1:0];
        REG_WARN_PERMILLE: regs_nxt.warn_permille = pwdata[REG_BITS-1:0];
        REG_FULL_PERMILLE: regs_nxt.full_permille = pwdata[REG_BITS-1:0];
        REG_OVER_PERMILLE: regs_nxt.over_permille = pwdata[REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENTRY_COUNT:   prdata = CFG_DATA_BITS'(regs_r.entry_count);
      REG_MIN_CAPACITY:  prdata = CFG_DATA_BITS'(regs_r.min_capacity);
      REG_WARN_PERMILLE: prdata = CFG_DATA_BITS'(regs_r.warn_permille);
      REG_FULL_PERMILLE: prdata = CFG_DATA_BITS'(regs_r.full_permille);
      REG_OVER_PERMILLE: prdata = CFG_DATA_BITS'(regs_r.over_permille);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.entry_count <= '0;
      regs_r.min_capacity <= REG_BITS'(100);
      regs_r.warn_permille <= REG_BITS'(950);
      regs_r.full_permille <= REG_BITS'(1000);
      regs_r.over_permille <= REG_BITS'(1050);
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ----- rtl/rllc_div.sv -----
`timescale 1ns / 1ps

module rllc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rllc_pkg::DVD_BITS-1:0]   dividend,
  input  logic [rllc_pkg::VALUE_BITS-1:0] divisor,
  output logic                            done,
  output logic [rllc_pkg::DVD_BITS-1:0]   quotient
);
  import rllc_pkg::*;

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] dsr_r, dsr_nxt;
  logic [DVD_BITS-1:0] dvd_r, dvd_nxt;
  logic [VALUE_BITS:0] rem_sh;
  logic [VALUE_BITS:0] rem_diff;
  logic ge;

  assign rem_sh = {rem_r, dvd_r[DVD_BITS-1]};
  assign ge = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    dvd_nxt = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = DIV_CNT_BITS'(DVD_BITS);
      rem_nxt = '0;
      dsr_nxt = divisor;
      dvd_nxt = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_diff[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
      dvd_nxt = {dvd_r[DVD_BITS-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_BITS'(1);
      if (cnt_r == DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign quotient = dvd_r;

endmodule

// ----- rtl/rated_load_limit_classifier.sv -----
`timescale 1ns / 1ps

// Rated load limiter. A write word stores one capacity chart entry and is taken with no result.
// A sample word walks the chart from slot 0, with a read state and a check state for each entry
// examined because the chart sits in a RAM with registered read, until it finds
// the first radius at or above the trolley position (or the last entry in use). It then runs
// the load-times-1000 quotient through a restoring divider that produces one quotient bit per
// cycle, and then hands over the quotient. A sample that faults skips the divider. The input is
// not ready while a sample is in progress; one finished result may wait in the output
// register while the next word is accepted.

module rated_load_limit_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  rllc_in_if.sink                            in_ch,
  rllc_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rllc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [rllc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [rllc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import rllc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  cfg_regs_t cfg;

  state_t state_r, state_nxt;
  logic [ADDR_BITS-1:0] idx_r, idx_nxt;
  logic [CNT_BITS-1:0] n_r, n_nxt;
  logic [VALUE_BITS-1:0] pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] load_r, load_nxt;

  logic [LEVEL_BITS-1:0] res_level_r, res_level_nxt;
  logic [VALUE_BITS-1:0] res_permille_r, res_permille_nxt;
  logic res_fault_r, res_fault_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [LEVEL_BITS-1:0] out_level_r, out_level_nxt;
  logic [VALUE_BITS-1:0] out_permille_r, out_permille_nxt;
  logic out_fault_r, out_fault_nxt;

  logic [CNT_BITS-1:0] n_clamp;
  logic [ADDR_BITS-1:0] last_idx;
  logic ram_we;
  logic [2*VALUE_BITS-1:0] ram_rdata;
  logic [VALUE_BITS-1:0] rd_radius;
  logic [VALUE_BITS-1:0] rd_cap;
  logic div_start;
  logic div_done;
  logic [DVD_BITS-1:0] div_dividend;
  logic [DVD_BITS-1:0] div_quot;
  logic [VALUE_BITS-1:0] ratio;
  logic [LEVEL_BITS-1:0] ratio_level;

  rllc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (cfg)
  );

  rllc_ram #(
    .WIDTH (2 * VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_chart (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_BITS'(in_ch.entry_index)),
    .wdata ({in_ch.entry_radius, in_ch.entry_capacity}),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  rllc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rd_cap),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign rd_radius = ram_rdata[2*VALUE_BITS-1:VALUE_BITS];
  assign rd_cap = ram_rdata[VALUE_BITS-1:0];
  assign div_dividend = DVD_BITS'(load_r) * PERMILLE_SCALE;
  assign last_idx = ADDR_BITS'(n_r - CNT_BITS'(1));

  always_comb begin
    if (CNT_BITS'(cfg.entry_count) > CNT_BITS'(TABLE_DEPTH)) begin
      n_clamp = CNT_BITS'(TABLE_DEPTH);
    end else begin
      n_clamp = CNT_BITS'(cfg.entry_count);
    end
  end

  always_comb begin
    if (|div_quot[DVD_BITS-1:VALUE_BITS]) begin
      ratio = '1;
    end else begin
      ratio = div_quot[VALUE_BITS-1:0];
    end
    if (ratio >= cfg.over_permille) begin
      ratio_level = LEVEL_OVERLOAD;
    end else if (ratio >= cfg.full_permille) begin
      ratio_level = LEVEL_FULL;
    end else if (ratio >= cfg.warn_permille) begin
      ratio_level = LEVEL_WARNING;
    end else begin
      ratio_level = LEVEL_NORMAL;
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    n_nxt = n_r;
    pos_nxt = pos_r;
    load_nxt = load_r;
    res_level_nxt = res_level_r;
    res_permille_nxt = res_permille_r;
    res_fault_nxt = res_fault_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_level_nxt = out_level_r;
    out_permille_nxt = out_permille_r;
    out_fault_nxt = out_fault_r;
    ram_we = 1'b0;
    div_start = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.func == FUNC_WRITE) begin
            ram_we = (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));
          end else begin
            pos_nxt = in_ch.trolley_position;
            load_nxt = in_ch.load_weight;
            n_nxt = n_clamp;
            idx_nxt = '0;
            if (n_clamp == '0) begin
              res_level_nxt = LEVEL_NORMAL;
              res_permille_nxt = '0;
              res_fault_nxt = 1'b1;
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if ((pos_r <= rd_radius) || (idx_r == last_idx)) begin
          if ((rd_cap == '0) || (rd_cap < cfg.min_capacity)) begin
            res_level_nxt = LEVEL_NORMAL;
            res_permille_nxt = '0;
            res_fault_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end else begin
          idx_nxt = idx_r + ADDR_BITS'(1);
          state_nxt = ST_READ;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_level_nxt = ratio_level;
          res_permille_nxt = ratio;
          res_fault_nxt = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = res_level_r;
          out_permille_nxt = res_permille_r;
          out_fault_nxt = res_fault_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      n_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r <= idx_nxt;
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    load_r <= load_nxt;
    res_level_r <= res_level_nxt;
    res_permille_r <= res_permille_nxt;
    res_fault_r <= res_fault_nxt;
    out_level_r <= out_level_nxt;
    out_permille_r <= out_permille_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.level = out_level_r;
  assign out_ch.load_permille = out_permille_r;
  assign out_ch.capacity_fault = out_fault_r;

`ifndef SYNTHESIS
  a_fault_clears_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.capacity_fault |->
      (out_ch.level == LEVEL_NORMAL) && (out_ch.load_permille == '0))
    else $error("Faulted result carries a nonzero level or ratio.");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (n_r != '0) && (CNT_BITS'(idx_r) < n_r))
    else $error("Chart walk index beyond the entries in use.");

  a_div_valid_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (rd_cap != '0) && (rd_cap >= cfg.min_capacity))
    else $error("Divider started with an invalid rated load.");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("Divider finished outside the divide state.");
`endif

endmodule
